[hw/rtl/bplru_pkg.sv]
// Shared types, constants and link helpers for the buffer pool LRU pin manager.
// Used by bplru_ctrl, bplru_dp and buffer_pool_lru_pin_manager; no dependencies.
package bplru_pkg;

	localparam int SLOTS  = 64;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int LINK_W = IDX_W + 1;
	localparam int FILE_W = 16;
	localparam int PAGE_W = 32;
	localparam int PIN_W  = 16;
	localparam int SLOT_OUT_W = 6;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [LINK_W-1:0] link_t;
	typedef logic [IDX_W:0]    cnt_t;
	typedef logic [PIN_W-1:0]  pin_t;

	localparam link_t NIL       = {LINK_W{1'b1}};
	localparam cnt_t  SLOTS_CNT = cnt_t'(SLOTS);
	localparam pin_t  PIN_MAX   = {PIN_W{1'b1}};

	typedef enum logic [1:0] {
		OP_GET   = 2'd0,
		OP_DIRTY = 2'd1,
		OP_UNPIN = 2'd2,
		OP_FORCE = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RD,
		ST_EVAL,
		ST_WALK,
		ST_WALK_EV,
		ST_DET,
		ST_LNK,
		ST_HEAD,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_START,
		CMD_SCAN,
		CMD_HIT_GET,
		CMD_HIT_DIRTY,
		CMD_HIT_UNPIN,
		CMD_HIT_FORCE,
		CMD_TAKE_FREE,
		CMD_WALK_NEXT,
		CMD_EVICT,
		CMD_NOBUF,
		CMD_DET,
		CMD_LNK,
		CMD_HEAD
	} cmd_t;

	typedef struct packed {
		logic scan_hit;
		logic scan_miss;
		op_t  op;
		logic hit;
		logic free_ok;
		logic tgt_ok;
		logic walk_end;
		logic pin_zero;
		logic unpin_zero;
	} dp_status_t;

	function automatic logic link_ok(link_t l);
		return int'(l) < SLOTS;
	endfunction

	function automatic link_t next_init(idx_t i);
		if (int'(i) + 1 < SLOTS) begin
			return link_t'(int'(i) + 1);
		end
		return NIL;
	endfunction

	function automatic link_t prev_init(idx_t i);
		if (int'(i) == 0) begin
			return NIL;
		end
		return link_t'(int'(i) - 1);
	endfunction

endpackage

[hw/rtl/bplru_ctrl.sv]
// Sequencer for the buffer pool manager: scan, victim walk and list relinking.
// Depends on bplru_pkg; drives bplru_dp by one command per cycle.
module bplru_ctrl
	import bplru_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t sts,
	output cmd_t       cmd,
	output logic       busy,
	output logic       done
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd     = CMD_START;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd = CMD_SCAN;
				if (sts.scan_hit) begin
					state_d = ST_RD;
				end else if (sts.scan_miss) begin
					if (sts.op != OP_GET) begin
						state_d = ST_DONE;
					end else if (sts.free_ok) begin
						state_d = ST_RD;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_RD: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (sts.hit) begin
					case (sts.op)
						OP_GET: begin
							cmd     = CMD_HIT_GET;
							state_d = ST_DET;
						end
						OP_DIRTY: begin
							cmd     = CMD_HIT_DIRTY;
							state_d = ST_DET;
						end
						OP_UNPIN: begin
							cmd     = CMD_HIT_UNPIN;
							state_d = sts.unpin_zero ? ST_DET : ST_DONE;
						end
						default: begin
							cmd     = CMD_HIT_FORCE;
							state_d = ST_DONE;
						end
					endcase
				end else begin
					// free slot is on the free list, not the LRU list: link it straight in at the head
					cmd     = CMD_TAKE_FREE;
					state_d = ST_LNK;
				end
			end
			ST_WALK: begin
				if (!sts.tgt_ok || sts.walk_end) begin
					cmd     = CMD_NOBUF;
					state_d = ST_DONE;
				end else begin
					state_d = ST_WALK_EV;
				end
			end
			ST_WALK_EV: begin
				if (sts.pin_zero) begin
					cmd     = CMD_EVICT;
					state_d = ST_DET;
				end else begin
					cmd     = CMD_WALK_NEXT;
					state_d = ST_WALK;
				end
			end
			ST_DET: begin
				cmd     = CMD_DET;
				state_d = ST_LNK;
			end
			ST_LNK: begin
				cmd     = CMD_LNK;
				state_d = ST_HEAD;
			end
			ST_HEAD: begin
				cmd     = CMD_HEAD;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

[hw/rtl/bplru_dp.sv]
// Datapath of the buffer pool manager: slot memories, valid bits, list pointers
// and result registers. Depends on bplru_pkg; commanded by bplru_ctrl.
module bplru_dp
	import bplru_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  logic [1:0]            op,
	input  logic [FILE_W-1:0]     file_id,
	input  logic [PAGE_W-1:0]     page_num,
	output dp_status_t            sts,
	output logic                  status,
	output logic                  hit,
	output logic [SLOT_OUT_W-1:0] slot_index,
	output logic                  fill_needed,
	output logic                  writeback_needed,
	output logic [FILE_W-1:0]     wb_file_id,
	output logic [PAGE_W-1:0]     wb_page_num
);

	localparam int KEY_W = FILE_W + PAGE_W;

	logic [KEY_W-1:0] key_mem [SLOTS];
	pin_t             pin_mem [SLOTS];
	link_t            next_mem[SLOTS];
	link_t            prev_mem[SLOTS];

	logic [SLOTS-1:0] res_q, dirty_q, nvld_q, pvld_q;

	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	link_t            head_q, tail_q, free_q, tgt_q;
	cnt_t             cnt_q, walk_q;
	logic             s1_v_q;
	idx_t             s1_idx_q;

	idx_t             raddr, raddr_q;
	logic [KEY_W-1:0] rd_key_q;
	pin_t             rd_pin_q;
	link_t            rd_nmem_q, rd_pmem_q;
	logic             rd_nv_q, rd_pv_q;
	link_t            rd_next, rd_prev;

	logic             match;
	idx_t             tgt_idx;
	logic             install;

	// next/prev memory write ports
	logic  nwe, pwe;
	idx_t  nwa, pwa;
	link_t nwd, pwd;

	assign tgt_idx = tgt_q[IDX_W-1:0];
	assign raddr   = (cmd == CMD_SCAN) ? cnt_q[IDX_W-1:0] : tgt_idx;
	assign rd_next = rd_nv_q ? rd_nmem_q : next_init(raddr_q);
	assign rd_prev = rd_pv_q ? rd_pmem_q : prev_init(raddr_q);
	assign match   = s1_v_q && res_q[s1_idx_q] && (rd_key_q == key_q);
	assign install = (cmd == CMD_TAKE_FREE) || (cmd == CMD_EVICT);

	always_comb begin
		sts.scan_hit   = (cmd == CMD_SCAN) && match;
		sts.scan_miss  = !match && !s1_v_q && (cnt_q == SLOTS_CNT);
		sts.op         = op_q;
		sts.hit        = hit;
		sts.free_ok    = link_ok(free_q);
		sts.tgt_ok     = link_ok(tgt_q);
		sts.walk_end   = (walk_q == SLOTS_CNT);
		sts.pin_zero   = (rd_pin_q == '0);
		sts.unpin_zero = (rd_pin_q <= pin_t'(1));
	end

	always_comb begin
		nwe = 1'b0;
		pwe = 1'b0;
		nwa = rd_prev[IDX_W-1:0];
		pwa = rd_next[IDX_W-1:0];
		nwd = link_ok(rd_next) ? rd_next : NIL;
		pwd = link_ok(rd_prev) ? rd_prev : NIL;
		case (cmd)
			CMD_DET: begin
				nwe = link_ok(rd_prev);
				pwe = link_ok(rd_next);
			end
			CMD_LNK: begin
				nwe = 1'b1;
				nwa = tgt_idx;
				nwd = link_ok(head_q) ? head_q : NIL;
				pwe = 1'b1;
				pwa = tgt_idx;
				pwd = NIL;
			end
			CMD_HEAD: begin
				pwe = link_ok(head_q);
				pwa = head_q[IDX_W-1:0];
				pwd = tgt_q;
			end
			default: begin
			end
		endcase
	end

	// memories: clocked read every cycle, one write port each
	always_ff @(posedge clk) begin
		rd_key_q  <= key_mem[raddr];
		rd_pin_q  <= pin_mem[raddr];
		rd_nmem_q <= next_mem[raddr];
		rd_pmem_q <= prev_mem[raddr];
		raddr_q   <= raddr;
		if (nwe) begin
			next_mem[nwa] <= nwd;
		end
		if (pwe) begin
			prev_mem[pwa] <= pwd;
		end
		if (install) begin
			key_mem[tgt_idx] <= key_q;
			pin_mem[tgt_idx] <= pin_t'(1);
		end else if (cmd == CMD_HIT_GET) begin
			pin_mem[tgt_idx] <= (rd_pin_q != PIN_MAX) ? rd_pin_q + pin_t'(1) : rd_pin_q;
		end else if (cmd == CMD_HIT_UNPIN) begin
			pin_mem[tgt_idx] <= (rd_pin_q != '0) ? rd_pin_q - pin_t'(1) : rd_pin_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q    <= '0;
			dirty_q  <= '0;
			nvld_q   <= '0;
			pvld_q   <= '0;
			rd_nv_q  <= 1'b0;
			rd_pv_q  <= 1'b0;
			head_q   <= NIL;
			tail_q   <= NIL;
			free_q   <= '0;
			tgt_q    <= NIL;
			cnt_q    <= '0;
			walk_q   <= '0;
			s1_v_q   <= 1'b0;
			s1_idx_q <= '0;
			op_q     <= OP_GET;
			key_q    <= '0;
			status           <= 1'b0;
			hit              <= 1'b0;
			slot_index       <= '0;
			fill_needed      <= 1'b0;
			writeback_needed <= 1'b0;
			wb_file_id       <= '0;
			wb_page_num      <= '0;
		end else begin
			rd_nv_q <= nvld_q[raddr];
			rd_pv_q <= pvld_q[raddr];
			if (nwe) begin
				nvld_q[nwa] <= 1'b1;
			end
			if (pwe) begin
				pvld_q[pwa] <= 1'b1;
			end
			case (cmd)
				CMD_START: begin
					op_q             <= op_t'(op);
					key_q            <= {file_id, page_num};
					cnt_q            <= '0;
					s1_v_q           <= 1'b0;
					status           <= 1'b0;
					hit              <= 1'b0;
					slot_index       <= '0;
					fill_needed      <= 1'b0;
					writeback_needed <= 1'b0;
					wb_file_id       <= '0;
					wb_page_num      <= '0;
				end
				CMD_SCAN: begin
					// read slot cnt now, compare it next cycle; stop on lowest match
					if (cnt_q != SLOTS_CNT) begin
						cnt_q <= cnt_q + cnt_t'(1);
					end
					s1_v_q   <= (cnt_q != SLOTS_CNT) && !match;
					s1_idx_q <= cnt_q[IDX_W-1:0];
					if (match) begin
						hit        <= 1'b1;
						slot_index <= SLOT_OUT_W'(s1_idx_q);
						tgt_q      <= link_t'(s1_idx_q);
					end else if (sts.scan_miss) begin
						tgt_q  <= link_ok(free_q) ? free_q : tail_q;
						walk_q <= '0;
					end
				end
				CMD_HIT_DIRTY: begin
					dirty_q[tgt_idx] <= 1'b1;
				end
				CMD_HIT_FORCE: begin
					if (dirty_q[tgt_idx]) begin
						writeback_needed <= 1'b1;
						wb_file_id       <= rd_key_q[KEY_W-1:PAGE_W];
						wb_page_num      <= rd_key_q[PAGE_W-1:0];
						dirty_q[tgt_idx] <= 1'b0;
					end
				end
				CMD_TAKE_FREE: begin
					free_q           <= link_ok(rd_next) ? rd_next : NIL;
					res_q[tgt_idx]   <= 1'b1;
					dirty_q[tgt_idx] <= 1'b0;
					slot_index       <= SLOT_OUT_W'(tgt_idx);
					fill_needed      <= 1'b1;
				end
				CMD_EVICT: begin
					if (dirty_q[tgt_idx]) begin
						writeback_needed <= 1'b1;
						wb_file_id       <= rd_key_q[KEY_W-1:PAGE_W];
						wb_page_num      <= rd_key_q[PAGE_W-1:0];
					end
					res_q[tgt_idx]   <= 1'b1;
					dirty_q[tgt_idx] <= 1'b0;
					slot_index       <= SLOT_OUT_W'(tgt_idx);
					fill_needed      <= 1'b1;
				end
				CMD_WALK_NEXT: begin
					tgt_q  <= rd_prev;
					walk_q <= walk_q + cnt_t'(1);
				end
				CMD_NOBUF: begin
					status <= 1'b1;
				end
				CMD_DET: begin
					if (head_q == tgt_q) begin
						head_q <= link_ok(rd_next) ? rd_next : NIL;
					end
					if (tail_q == tgt_q) begin
						tail_q <= link_ok(rd_prev) ? rd_prev : NIL;
					end
				end
				CMD_HEAD: begin
					head_q <= tgt_q;
					if (!link_ok(tail_q)) begin
						tail_q <= tgt_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[hw/rtl/buffer_pool_lru_pin_manager.sv]
// Top level of the buffer pool LRU pin manager: controller plus datapath.
// Depends on bplru_pkg, bplru_ctrl and bplru_dp.
//
//   channel   handshake            payload
//   request   start && !busy       op, file_id, page_num
//   result    done (one cycle)     status, hit, slot_index, fill_needed,
//                                  writeback_needed, wb_file_id, wb_page_num
//
// From the accepting edge through done: the key scan reads one slot per cycle and stops
// on the lowest matching slot, or after all SLOTS slots on a miss. A hit is then relinked at
// the LRU head (get, dirty, or an unpin that reaches zero pins), else it ends; a miss ends at
// once (not a get), takes a free slot, evicts a victim found by the walk, or reports no buffer.
// Reset is immediate: all slots free, LRU list empty, no reset sweep needed.
// One request in work at a time, busy high through done; the receiver cannot stall.
module buffer_pool_lru_pin_manager
	import bplru_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            op,
	input  logic [FILE_W-1:0]     file_id,
	input  logic [PAGE_W-1:0]     page_num,
	output logic                  done,
	output logic                  status,
	output logic                  hit,
	output logic [SLOT_OUT_W-1:0] slot_index,
	output logic                  fill_needed,
	output logic                  writeback_needed,
	output logic [FILE_W-1:0]     wb_file_id,
	output logic [PAGE_W-1:0]     wb_page_num
);

	cmd_t       cmd;
	dp_status_t sts;

	bplru_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bplru_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.op               (op),
		.file_id          (file_id),
		.page_num         (page_num),
		.sts              (sts),
		.status           (status),
		.hit              (hit),
		.slot_index       (slot_index),
		.fill_needed      (fill_needed),
		.writeback_needed (writeback_needed),
		.wb_file_id       (wb_file_id),
		.wb_page_num      (wb_page_num)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result transfer outside a busy period");

	a_nobuf_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> !hit && !fill_needed && !writeback_needed)
		else $error("no-buffer result carries other flags");

	a_fill_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && fill_needed |-> !hit && !status)
		else $error("fill reported on a hit");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted request did not enter work");

endmodule
